FILE: sv/dpp_pkg.sv
package dpp_pkg;

  // field widths
  localparam int RAW_W     = 16;
  localparam int COL_W     = 10;
  localparam int ROW_W     = 9;
  localparam int XY_W      = 22;
  localparam int Z_W       = 20;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CTR_W     = 19;
  localparam int INV_W     = 24;
  localparam int ZS_W      = 16;

  // internal widths
  localparam int DEPTH_W   = 20;             // Q4.16 depth, one quotient bit per stage
  localparam int D_W       = 49;             // slope * raw + offset, signed
  localparam int DIV_D_W   = 45;             // divisor / remainder width in range
  localparam int MAG_W     = 20;             // |coord - center|, Q.8
  localparam int PROD_W    = MAG_W + DEPTH_W;
  localparam int HALF_W    = PROD_W / 2;
  localparam int PART_W    = HALF_W + INV_W;

  localparam int FRONT_STAGES = 3;
  localparam int PROJ_STAGES  = 4;
  localparam int PIPE_LAT     = FRONT_STAGES + DEPTH_W + PROJ_STAGES;

  // d <= 2^24 saturates depth, d > 2^44 gives depth zero
  localparam logic signed [D_W-1:0] D_SAT_LIM = D_W'(64'd16777216);
  localparam logic signed [D_W-1:0] D_BIG_LIM = D_W'(64'd17592186044416);

  // register reset values
  localparam logic signed [31:0] RST_DEPTH_SLOPE  = -32'sd824393;
  localparam logic signed [31:0] RST_DEPTH_OFFSET = 32'sd894144952;
  localparam logic [CTR_W-1:0]   RST_CENTER_X     = 19'd86863;
  localparam logic [CTR_W-1:0]   RST_CENTER_Y     = 19'd62141;
  localparam logic [INV_W-1:0]   RST_INV_FOCAL_X  = 24'd28234;
  localparam logic [INV_W-1:0]   RST_INV_FOCAL_Y  = 24'd28386;
  localparam logic [ZS_W-1:0]    RST_Z_SCALE      = 16'd26214;
  localparam logic [RAW_W-1:0]   RST_RAW_LIMIT    = 16'd2047;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH_SLOPE  = 3'd0,
    REG_DEPTH_OFFSET = 3'd1,
    REG_CENTER_X     = 3'd2,
    REG_CENTER_Y     = 3'd3,
    REG_INV_FOCAL_X  = 3'd4,
    REG_INV_FOCAL_Y  = 3'd5,
    REG_Z_SCALE      = 3'd6,
    REG_RAW_LIMIT    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] depth_slope;
    logic signed [31:0] depth_offset;
    logic [CTR_W-1:0]   center_x;
    logic [CTR_W-1:0]   center_y;
    logic [INV_W-1:0]   inv_focal_x;
    logic [INV_W-1:0]   inv_focal_y;
    logic [ZS_W-1:0]    z_scale;
    logic [RAW_W-1:0]   raw_limit;
  } cfg_t;

  // per-beat sideband that rides along the divider
  typedef struct packed {
    logic             ok;     // below limit and d > 0
    logic             sat;    // depth clamps to max
    logic             big;    // depth is zero
    logic             neg_x;
    logic [MAG_W-1:0] mag_x;
    logic             neg_y;
    logic [MAG_W-1:0] mag_y;
  } side_t;

endpackage

FILE: sv/dpp_cfg.sv
module dpp_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dpp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpp_pkg::CFG_W-1:0]      cfg_data,
  output dpp_pkg::cfg_t                  cfg
);

  dpp_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (dpp_pkg::cfg_idx_t'(cfg_index))
        dpp_pkg::REG_DEPTH_SLOPE:  cfg_nxt.depth_slope  = $signed(cfg_data);
        dpp_pkg::REG_DEPTH_OFFSET: cfg_nxt.depth_offset = $signed(cfg_data);
        dpp_pkg::REG_CENTER_X:     cfg_nxt.center_x     = cfg_data[dpp_pkg::CTR_W-1:0];
        dpp_pkg::REG_CENTER_Y:     cfg_nxt.center_y     = cfg_data[dpp_pkg::CTR_W-1:0];
        dpp_pkg::REG_INV_FOCAL_X:  cfg_nxt.inv_focal_x  = cfg_data[dpp_pkg::INV_W-1:0];
        dpp_pkg::REG_INV_FOCAL_Y:  cfg_nxt.inv_focal_y  = cfg_data[dpp_pkg::INV_W-1:0];
        dpp_pkg::REG_Z_SCALE:      cfg_nxt.z_scale      = cfg_data[dpp_pkg::ZS_W-1:0];
        dpp_pkg::REG_RAW_LIMIT:    cfg_nxt.raw_limit    = cfg_data[dpp_pkg::RAW_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth_slope  <= dpp_pkg::RST_DEPTH_SLOPE;
      cfg_r.depth_offset <= dpp_pkg::RST_DEPTH_OFFSET;
      cfg_r.center_x     <= dpp_pkg::RST_CENTER_X;
      cfg_r.center_y     <= dpp_pkg::RST_CENTER_Y;
      cfg_r.inv_focal_x  <= dpp_pkg::RST_INV_FOCAL_X;
      cfg_r.inv_focal_y  <= dpp_pkg::RST_INV_FOCAL_Y;
      cfg_r.z_scale      <= dpp_pkg::RST_Z_SCALE;
      cfg_r.raw_limit    <= dpp_pkg::RST_RAW_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: sv/dpp_front.sv
module dpp_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_fire,
  input  logic [dpp_pkg::RAW_W-1:0]    depth_raw,
  input  logic [dpp_pkg::COL_W-1:0]    column,
  input  logic [dpp_pkg::ROW_W-1:0]    row,
  input  dpp_pkg::cfg_t                cfg,
  output logic                         side_valid,
  output dpp_pkg::side_t               side,
  output logic [dpp_pkg::DIV_D_W-1:0]  div_d
);

  // stage 1: slope * raw, limit check, lateral offsets
  logic                              v1_r;
  logic signed [dpp_pkg::D_W-1:0]    prod1_r, prod1_nxt;
  dpp_pkg::side_t                    s1_r, s1_nxt;
  logic signed [dpp_pkg::D_W-1:0]    slope_ext, raw_ext;
  logic signed [dpp_pkg::MAG_W:0]    dx, dy;

  always_comb begin
    slope_ext = dpp_pkg::D_W'(cfg.depth_slope);
    raw_ext   = $signed({{(dpp_pkg::D_W - dpp_pkg::RAW_W){1'b0}}, depth_raw});
    prod1_nxt = slope_ext * raw_ext;

    dx = $signed({3'b000, column, 8'h00}) - $signed({2'b00, cfg.center_x});
    dy = $signed({4'h0, row, 8'h00}) - $signed({2'b00, cfg.center_y});

    s1_nxt       = '0;
    s1_nxt.ok    = depth_raw < cfg.raw_limit;
    s1_nxt.neg_x = dx[dpp_pkg::MAG_W];
    s1_nxt.mag_x = dx[dpp_pkg::MAG_W] ? dpp_pkg::MAG_W'(-dx) : dx[dpp_pkg::MAG_W-1:0];
    s1_nxt.neg_y = dy[dpp_pkg::MAG_W];
    s1_nxt.mag_y = dy[dpp_pkg::MAG_W] ? dpp_pkg::MAG_W'(-dy) : dy[dpp_pkg::MAG_W-1:0];
  end

  // stage 2: add offset
  logic                              v2_r;
  logic signed [dpp_pkg::D_W-1:0]    d2_r, d2_nxt;
  dpp_pkg::side_t                    s2_r;

  assign d2_nxt = prod1_r + dpp_pkg::D_W'(cfg.depth_offset);

  // stage 3: classify d
  logic                              v3_r;
  dpp_pkg::side_t                    s3_r, s3_nxt;
  logic [dpp_pkg::DIV_D_W-1:0]       d3_r;

  always_comb begin
    s3_nxt     = s2_r;
    s3_nxt.ok  = s2_r.ok && (d2_r > 0);
    s3_nxt.sat = d2_r <= dpp_pkg::D_SAT_LIM;
    s3_nxt.big = d2_r > dpp_pkg::D_BIG_LIM;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_fire;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    prod1_r <= prod1_nxt;
    s1_r    <= s1_nxt;
    d2_r    <= d2_nxt;
    s2_r    <= s1_r;
    s3_r    <= s3_nxt;
    d3_r    <= d2_r[dpp_pkg::DIV_D_W-1:0];
  end

  assign side_valid = v3_r;
  assign side       = s3_r;
  assign div_d      = d3_r;

endmodule

FILE: sv/dpp_recip.sv
module dpp_recip (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         side_valid_in,
  input  dpp_pkg::side_t               side_in,
  input  logic [dpp_pkg::DIV_D_W-1:0]  div_d,
  output logic                         side_valid_out,
  output dpp_pkg::side_t               side_out,
  output logic [dpp_pkg::DEPTH_W-1:0]  quo
);

  localparam int N   = dpp_pkg::DEPTH_W;
  localparam int W   = dpp_pkg::DIV_D_W;
  // 2^44 = 2^24 * 2^N: the top part seeds the remainder, the rest are zero bits
  localparam logic [W-1:0] REM_INIT = W'(1) << 24;

  typedef struct packed {
    logic [W-1:0] rem;
    logic [W-1:0] d;
    logic [N-1:0] q;
  } div_t;

  div_t           st_r   [N];
  dpp_pkg::side_t side_r [N];
  logic [N-1:0]   v_r;

  for (genvar k = 0; k < N; k++) begin : g_stage
    div_t           src;
    dpp_pkg::side_t src_side;
    logic           src_v;
    div_t           st_nxt;
    logic [W:0]     two, dif;
    logic           ge;

    if (k == 0) begin : g_first
      assign src      = '{rem: REM_INIT, d: div_d, q: '0};
      assign src_side = side_in;
      assign src_v    = side_valid_in;
    end else begin : g_next
      assign src      = st_r[k-1];
      assign src_side = side_r[k-1];
      assign src_v    = v_r[k-1];
    end

    // one restoring step: shift in a zero, subtract if it fits
    always_comb begin
      two          = {src.rem, 1'b0};
      dif          = two - {1'b0, src.d};
      ge           = two >= {1'b0, src.d};
      st_nxt.d     = src.d;
      st_nxt.rem   = ge ? dif[W-1:0] : two[W-1:0];
      st_nxt.q     = {src.q[N-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= src_v;
      end
      st_r[k]   <= st_nxt;
      side_r[k] <= src_side;
    end
  end

  assign side_valid_out = v_r[N-1];
  assign side_out       = side_r[N-1];
  assign quo            = st_r[N-1].q;

endmodule

FILE: sv/dpp_proj.sv
module dpp_proj (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                side_valid,
  input  dpp_pkg::side_t                      side,
  input  logic [dpp_pkg::DEPTH_W-1:0]         quo,
  input  dpp_pkg::cfg_t                       cfg,
  output logic                                out_valid,
  output logic signed [dpp_pkg::XY_W-1:0]     out_point_x,
  output logic signed [dpp_pkg::XY_W-1:0]     out_point_y,
  output logic [dpp_pkg::Z_W-1:0]             out_point_z,
  output logic                                out_depth_valid
);

  localparam int DW  = dpp_pkg::DEPTH_W;
  localparam int PW  = dpp_pkg::PROD_W;
  localparam int HW  = dpp_pkg::HALF_W;
  localparam int QW  = dpp_pkg::PART_W;
  localparam int XW  = dpp_pkg::XY_W;
  localparam int ZSW = dpp_pkg::ZS_W;
  localparam int TW  = QW + 1;
  localparam int LW  = TW - 12;     // coordinate before clamp, Q.16

  localparam logic [LW-1:0] POS_LIM = LW'(64'd2097151);
  localparam logic [LW-1:0] NEG_LIM = LW'(64'd2097152);

  function automatic logic [XW-1:0] sat_lat(input logic neg, input logic [LW-1:0] q);
    logic [XW-1:0] pos_v, neg_v;
    pos_v = (q > POS_LIM) ? POS_LIM[XW-1:0] : q[XW-1:0];
    neg_v = (q > NEG_LIM) ? NEG_LIM[XW-1:0] : (XW'(0) - q[XW-1:0]);
    return neg ? neg_v : pos_v;
  endfunction

  // stage D: clamp depth
  logic            vd_r;
  dpp_pkg::side_t  sd_r;
  logic [DW-1:0]   dep_r, dep_nxt;

  always_comb begin
    if (side.sat)      dep_nxt = '1;
    else if (side.big) dep_nxt = '0;
    else               dep_nxt = quo;
  end

  // stage M1: |diff| * depth, depth * z_scale
  logic               v1_r;
  dpp_pkg::side_t     s1_r;
  logic [PW-1:0]      ax1_r, ay1_r;
  logic [DW-1:0]      z1_r;
  logic [DW+ZSW-1:0]  zp;

  assign zp = {{ZSW{1'b0}}, dep_r} * {{DW{1'b0}}, cfg.z_scale};

  // stage M2: split the 40-bit product against inv_focal
  logic               v2_r;
  dpp_pkg::side_t     s2_r;
  logic [QW-1:0]      hx2_r, lx2_r, hy2_r, ly2_r;
  logic [DW-1:0]      z2_r;

  // output stage: recombine, drop Q.32 fraction, clamp
  logic [TW-1:0]      tx, ty;
  logic               vo_r;
  logic [XW-1:0]      xo_r, xo_nxt, yo_r, yo_nxt;
  logic [DW-1:0]      zo_r, zo_nxt;
  logic               ok_r;

  always_comb begin
    // low partial's bits below 2^20 never reach the kept bits
    tx = {1'b0, hx2_r} + {{(TW - (QW - HW)){1'b0}}, lx2_r[QW-1:HW]};
    ty = {1'b0, hy2_r} + {{(TW - (QW - HW)){1'b0}}, ly2_r[QW-1:HW]};
    xo_nxt = s2_r.ok ? sat_lat(s2_r.neg_x, tx[TW-1:12]) : '0;
    yo_nxt = s2_r.ok ? sat_lat(s2_r.neg_y, ty[TW-1:12]) : '0;
    zo_nxt = s2_r.ok ? z2_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      vd_r <= side_valid;
      v1_r <= vd_r;
      v2_r <= v1_r;
      vo_r <= v2_r;
    end
    sd_r  <= side;
    dep_r <= dep_nxt;

    s1_r  <= sd_r;
    ax1_r <= {{DW{1'b0}}, sd_r.mag_x} * {{dpp_pkg::MAG_W{1'b0}}, dep_r};
    ay1_r <= {{DW{1'b0}}, sd_r.mag_y} * {{dpp_pkg::MAG_W{1'b0}}, dep_r};
    z1_r  <= zp[DW+ZSW-1:ZSW];

    s2_r  <= s1_r;
    hx2_r <= {{dpp_pkg::INV_W{1'b0}}, ax1_r[PW-1:HW]} * {{HW{1'b0}}, cfg.inv_focal_x};
    lx2_r <= {{dpp_pkg::INV_W{1'b0}}, ax1_r[HW-1:0]}  * {{HW{1'b0}}, cfg.inv_focal_x};
    hy2_r <= {{dpp_pkg::INV_W{1'b0}}, ay1_r[PW-1:HW]} * {{HW{1'b0}}, cfg.inv_focal_y};
    ly2_r <= {{dpp_pkg::INV_W{1'b0}}, ay1_r[HW-1:0]}  * {{HW{1'b0}}, cfg.inv_focal_y};
    z2_r  <= z1_r;

    xo_r  <= xo_nxt;
    yo_r  <= yo_nxt;
    zo_r  <= zo_nxt;
    ok_r  <= s2_r.ok;
  end

  assign out_valid       = vo_r;
  assign out_point_x     = $signed(xo_r);
  assign out_point_y     = $signed(yo_r);
  assign out_point_z     = zo_r;
  assign out_depth_valid = ok_r;

endmodule

FILE: sv/depth_pixel_to_point.sv
// Depth pixel to 3-D point back-projection.
//
// Input: one beat per accepting edge (start high, busy low) carrying a raw
// depth sample with its column and row. busy is low whenever reset is
// released, so a new sample may enter on every cycle.
// Output: one beat per input, in order, shown for one cycle with out_valid.
// Throughput is one sample per cycle. The pipeline is a 20-stage restoring
// divider for the reciprocal, one quotient bit per stage, plus three front
// stages (multiply, add, classify) and four projection stages (clamp, two
// multiplier stages, recombine).
// Invalid samples (raw at or above the limit, or non-positive inverse depth)
// come out with depth_valid low and zero coordinates.
// The receiver cannot stall; there is no back-pressure anywhere.
// Synchronous reset empties the pipeline and restores the register defaults.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, which the block itself does not enforce.
module depth_pixel_to_point (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [dpp_pkg::RAW_W-1:0]          in_depth_raw,
  input  logic [dpp_pkg::COL_W-1:0]          in_column,
  input  logic [dpp_pkg::ROW_W-1:0]          in_row,
  output logic                               out_valid,
  output logic signed [dpp_pkg::XY_W-1:0]    out_point_x,
  output logic signed [dpp_pkg::XY_W-1:0]    out_point_y,
  output logic [dpp_pkg::Z_W-1:0]            out_point_z,
  output logic                               out_depth_valid,
  input  logic                               cfg_we,
  input  logic [dpp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dpp_pkg::CFG_W-1:0]          cfg_data
);

  dpp_pkg::cfg_t                 cfg;
  logic                          in_fire;
  logic                          f_valid, r_valid;
  dpp_pkg::side_t                f_side, r_side;
  logic [dpp_pkg::DIV_D_W-1:0]   f_d;
  logic [dpp_pkg::DEPTH_W-1:0]   r_quo;

  assign busy    = ~rst_n;
  assign in_fire = start & ~busy;

  dpp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dpp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .depth_raw  (in_depth_raw),
    .column     (in_column),
    .row        (in_row),
    .cfg        (cfg),
    .side_valid (f_valid),
    .side       (f_side),
    .div_d      (f_d)
  );

  dpp_recip u_recip (
    .clk            (clk),
    .rst_n          (rst_n),
    .side_valid_in  (f_valid),
    .side_in        (f_side),
    .div_d          (f_d),
    .side_valid_out (r_valid),
    .side_out       (r_side),
    .quo            (r_quo)
  );

  dpp_proj u_proj (
    .clk             (clk),
    .rst_n           (rst_n),
    .side_valid      (r_valid),
    .side            (r_side),
    .quo             (r_quo),
    .cfg             (cfg),
    .out_valid       (out_valid),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_point_z     (out_point_z),
    .out_depth_valid (out_depth_valid)
  );

endmodule

FILE: sv/dpp_chk.sv
module dpp_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_valid,
  input logic signed [dpp_pkg::XY_W-1:0]    out_point_x,
  input logic signed [dpp_pkg::XY_W-1:0]    out_point_y,
  input logic [dpp_pkg::Z_W-1:0]            out_point_z,
  input logic                               out_depth_valid
);

  localparam int LAT   = dpp_pkg::PIPE_LAT;
  localparam int CNT_W = $clog2(LAT + 1);

  logic             acc;
  logic [CNT_W-1:0] settle_r, settle_nxt;

  assign acc        = start && !busy;
  assign settle_nxt = (settle_r == CNT_W'(LAT)) ? settle_r : settle_r + 1'b1;

  // edges since reset, so a beat in flight across a reset is not expected out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= '0;
    end else begin
      settle_r <= settle_nxt;
    end
  end

  a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
    (settle_r == CNT_W'(LAT)) && $past(acc, LAT) |-> out_valid)
    else $error("accepted beat did not come out after pipeline latency");

  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, LAT))
    else $error("result beat without a matching input beat");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_depth_valid |->
      (out_point_x == '0) && (out_point_y == '0) && (out_point_z == '0))
    else $error("invalid sample carries nonzero coordinates");

  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind depth_pixel_to_point dpp_chk u_chk (.*);

FILE: test/depth_pixel_to_point_tb.sv
`timescale 1ns / 100ps

module testbench;

  typedef struct packed {
    logic signed [dpp_pkg::XY_W-1:0] x;
    logic signed [dpp_pkg::XY_W-1:0] y;
    logic [dpp_pkg::Z_W-1:0]         z;
    logic                            valid;
  } point_t;

  localparam logic [63:0] DEPTH_CAP  = 64'hFFFFF;
  localparam logic [63:0] XY_POS_CAP = 64'd2097151;
  localparam logic [63:0] XY_NEG_CAP = 64'd2097152;

  logic                            clk;
  logic                            rst_n = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  logic [dpp_pkg::RAW_W-1:0]       in_depth_raw = '0;
  logic [dpp_pkg::COL_W-1:0]       in_column = '0;
  logic [dpp_pkg::ROW_W-1:0]       in_row = '0;
  logic                            out_valid;
  logic signed [dpp_pkg::XY_W-1:0] out_point_x;
  logic signed [dpp_pkg::XY_W-1:0] out_point_y;
  logic [dpp_pkg::Z_W-1:0]         out_point_z;
  logic                            out_depth_valid;
  logic                            cfg_we = 1'b0;
  logic [dpp_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [dpp_pkg::CFG_W-1:0]       cfg_data = '0;

  dpp_pkg::cfg_t cam_cfg;
  point_t        expected_points[$];
  int            mismatches = 0;

  depth_pixel_to_point dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_depth_raw    (in_depth_raw),
    .in_column       (in_column),
    .in_row          (in_row),
    .out_valid       (out_valid),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_point_z     (out_point_z),
    .out_depth_valid (out_depth_valid),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // (coord - center) * depth * inv, truncated toward zero to Q.16, saturated
  function automatic logic [dpp_pkg::XY_W-1:0] lateral_coord(
      logic [dpp_pkg::COL_W-1:0] coord, logic [dpp_pkg::CTR_W-1:0] center,
      logic [dpp_pkg::DEPTH_W-1:0] depth, logic [dpp_pkg::INV_W-1:0] inv);
    longint      diff;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] q;
    logic [63:0] neg_q;
    diff = (longint'(coord) <<< 8) - longint'(center);
    if (diff < 0) mag = 64'(-diff);
    else mag = 64'(diff);
    prod = mag * depth * inv;
    q = prod >> 32;
    if (diff >= 0) begin
      return (q > XY_POS_CAP) ? XY_POS_CAP[dpp_pkg::XY_W-1:0] : q[dpp_pkg::XY_W-1:0];
    end
    if (q > XY_NEG_CAP) q = XY_NEG_CAP;
    neg_q = 64'd0 - q;
    return neg_q[dpp_pkg::XY_W-1:0];
  endfunction

  function automatic point_t project_pixel(logic [dpp_pkg::RAW_W-1:0] raw,
                                           logic [dpp_pkg::COL_W-1:0] col,
                                           logic [dpp_pkg::ROW_W-1:0] row);
    point_t                      p;
    longint                      inv_depth;
    logic [63:0]                 depth_q;
    logic [63:0]                 z_full;
    logic [dpp_pkg::DEPTH_W-1:0] depth;
    p = '0;
    if (raw >= cam_cfg.raw_limit) return p;
    inv_depth = longint'($signed(cam_cfg.depth_slope)) * longint'(raw)
              + longint'($signed(cam_cfg.depth_offset));
    if (inv_depth <= 0) return p;
    depth_q = (64'd1 << 44) / 64'(inv_depth);
    if (depth_q > DEPTH_CAP) depth_q = DEPTH_CAP;
    depth = depth_q[dpp_pkg::DEPTH_W-1:0];
    p.x = lateral_coord(col, cam_cfg.center_x, depth, cam_cfg.inv_focal_x);
    p.y = lateral_coord(dpp_pkg::COL_W'(row), cam_cfg.center_y, depth, cam_cfg.inv_focal_y);
    z_full = (64'(depth) * cam_cfg.z_scale) >> 16;
    p.z = z_full[dpp_pkg::Z_W-1:0];
    p.valid = 1'b1;
    return p;
  endfunction

  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // leaves cfg_we high; program_camera lowers it after the last beat
  task automatic write_reg(dpp_pkg::cfg_idx_t idx, logic [dpp_pkg::CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      dpp_pkg::REG_DEPTH_SLOPE:  cam_cfg.depth_slope = data;
      dpp_pkg::REG_DEPTH_OFFSET: cam_cfg.depth_offset = data;
      dpp_pkg::REG_CENTER_X:     cam_cfg.center_x = data[dpp_pkg::CTR_W-1:0];
      dpp_pkg::REG_CENTER_Y:     cam_cfg.center_y = data[dpp_pkg::CTR_W-1:0];
      dpp_pkg::REG_INV_FOCAL_X:  cam_cfg.inv_focal_x = data[dpp_pkg::INV_W-1:0];
      dpp_pkg::REG_INV_FOCAL_Y:  cam_cfg.inv_focal_y = data[dpp_pkg::INV_W-1:0];
      dpp_pkg::REG_Z_SCALE:      cam_cfg.z_scale = data[dpp_pkg::ZS_W-1:0];
      dpp_pkg::REG_RAW_LIMIT:    cam_cfg.raw_limit = data[dpp_pkg::RAW_W-1:0];
      default: ;
    endcase
  endtask

  // unused upper data bits carry noise
  task automatic program_camera(logic [31:0] slope, logic [31:0] offset,
                                logic [dpp_pkg::CTR_W-1:0] cx,
                                logic [dpp_pkg::CTR_W-1:0] cy,
                                logic [dpp_pkg::INV_W-1:0] ifx,
                                logic [dpp_pkg::INV_W-1:0] ify,
                                logic [dpp_pkg::ZS_W-1:0] zs,
                                logic [dpp_pkg::RAW_W-1:0] lim);
    wait_idle();
    write_reg(dpp_pkg::REG_DEPTH_SLOPE, slope);
    write_reg(dpp_pkg::REG_DEPTH_OFFSET, offset);
    write_reg(dpp_pkg::REG_CENTER_X, dpp_pkg::CFG_W'({$urandom, cx}));
    write_reg(dpp_pkg::REG_CENTER_Y, dpp_pkg::CFG_W'({$urandom, cy}));
    write_reg(dpp_pkg::REG_INV_FOCAL_X, dpp_pkg::CFG_W'({$urandom, ifx}));
    write_reg(dpp_pkg::REG_INV_FOCAL_Y, dpp_pkg::CFG_W'({$urandom, ify}));
    write_reg(dpp_pkg::REG_Z_SCALE, dpp_pkg::CFG_W'({$urandom, zs}));
    write_reg(dpp_pkg::REG_RAW_LIMIT, dpp_pkg::CFG_W'({$urandom, lim}));
    cfg_we <= 1'b0;
  endtask

  task automatic send_pixel(logic [dpp_pkg::RAW_W-1:0] raw, logic [dpp_pkg::COL_W-1:0] col,
                            logic [dpp_pkg::ROW_W-1:0] row, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_depth_raw <= raw;
    in_column <= col;
    in_row <= row;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_points.insert(expected_points.size(), project_pixel(raw, col, row));
  endtask

  // reset registers: near range, saturated depth, d crossing zero, limit, out of frame
  task automatic test_default_registers();
    send_pixel(16'd0, 10'd0, 9'd1, pick_gap(0));
    send_pixel(16'd0, 10'd639, 9'd480, pick_gap(0));
    send_pixel(16'd1000, 10'd1023, 9'd511, pick_gap(0));
    send_pixel(16'd1084, 10'd0, 9'd0, pick_gap(0));
    send_pixel(16'd1085, 10'd320, 9'd240, pick_gap(0));
    send_pixel(16'd2046, 10'd100, 9'd100, pick_gap(0));
    send_pixel(16'd2047, 10'd100, 9'd100, pick_gap(0));
    send_pixel(16'hFFFF, 10'd1023, 9'd511, pick_gap(0));
  endtask

  task automatic test_register_extremes();
    // d is exactly zero at raw 100, one at raw 99 (depth clamps)
    program_camera(-32'sd1, 32'sd100, 19'd0, 19'h7FFFF, 24'hFFFFFF, 24'hFFFFFF,
                   16'hFFFF, 16'hFFFF);
    send_pixel(16'd100, 10'd10, 9'd10, pick_gap(0));
    send_pixel(16'd99, 10'd1023, 9'd0, pick_gap(0));
    send_pixel(16'd99, 10'd0, 9'd511, pick_gap(0));
    send_pixel(16'd0, 10'd320, 9'd240, pick_gap(0));
    send_pixel(16'hFFFF, 10'd320, 9'd240, pick_gap(0));
    // at raw FFFE, d beyond 2^44 rounds depth to zero but stays valid
    program_camera(32'h7FFFFFFF, 32'h7FFFFFFF, 19'h7FFFF, 19'd0, 24'd0, 24'd1,
                   16'd0, 16'hFFFF);
    send_pixel(16'hFFFE, 10'd0, 9'd480, pick_gap(0));
    send_pixel(16'd0, 10'd0, 9'd480, pick_gap(0));
    send_pixel(16'd1, 10'd1023, 9'd511, pick_gap(0));
    // limit zero rejects everything
    program_camera(32'h80000000, 32'h80000000, 19'd0, 19'd0, 24'hFFFFFF, 24'hFFFFFF,
                   16'hFFFF, 16'd0);
    send_pixel(16'd0, 10'd0, 9'd1, pick_gap(0));
    send_pixel(16'hFFFF, 10'd639, 9'd480, pick_gap(0));
    // most negative offset: d negative, then -1, then positive
    program_camera(32'h7FFFFFFF, 32'h80000000, 19'd81920, 19'd61440, 24'd28234, 24'd28386,
                   16'd26214, 16'hFFFF);
    send_pixel(16'd0, 10'd0, 9'd1, pick_gap(0));
    send_pixel(16'd1, 10'd639, 9'd480, pick_gap(0));
    send_pixel(16'd2, 10'd100, 9'd300, pick_gap(0));
    send_pixel(16'hFFFE, 10'd500, 9'd20, pick_gap(0));
  endtask

  task automatic test_random_traffic();
    logic [31:0]               slope;
    logic [31:0]               offset;
    logic [dpp_pkg::CTR_W-1:0] cx;
    logic [dpp_pkg::CTR_W-1:0] cy;
    logic [dpp_pkg::INV_W-1:0] ifx;
    logic [dpp_pkg::INV_W-1:0] ify;
    logic [dpp_pkg::ZS_W-1:0]  zs;
    logic [dpp_pkg::RAW_W-1:0] lim;
    logic [dpp_pkg::RAW_W-1:0] raw;
    logic [dpp_pkg::COL_W-1:0] col;
    logic [dpp_pkg::ROW_W-1:0] row;
    int                        mode;
    int                        r;
    bit                        burst;
    for (int phase = 0; phase < 10; phase++) begin
      mode = (phase == 0) ? 3 : (phase - 1) % 3;
      case (mode)
        0: begin
          // plausible sensor: falling inverse depth, centers inside the frame
          slope = 32'd0 - 32'($urandom_range(1, 2000000));
          offset = $urandom_range(32'h0100_0000, 32'h7FFF_FFFF);
          cx = dpp_pkg::CTR_W'($urandom_range(0, 640 * 256));
          cy = dpp_pkg::CTR_W'($urandom_range(0, 480 * 256));
          ifx = dpp_pkg::INV_W'($urandom_range(0, 200000));
          ify = dpp_pkg::INV_W'($urandom_range(0, 200000));
          zs = dpp_pkg::ZS_W'($urandom);
          lim = dpp_pkg::RAW_W'($urandom_range(1, 4096));
        end
        1: begin
          slope = $urandom;
          offset = $urandom;
          cx = dpp_pkg::CTR_W'($urandom);
          cy = dpp_pkg::CTR_W'($urandom);
          ifx = dpp_pkg::INV_W'($urandom);
          ify = dpp_pkg::INV_W'($urandom);
          zs = dpp_pkg::ZS_W'($urandom);
          lim = dpp_pkg::RAW_W'($urandom);
        end
        2: begin
          case ($urandom_range(0, 3))
            0: slope = 32'h80000000;
            1: slope = 32'h7FFFFFFF;
            2: slope = 32'hFFFFFFFF;
            default: slope = 32'h00000001;
          endcase
          offset = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
          cx = $urandom_range(0, 1) ? '1 : '0;
          cy = $urandom_range(0, 1) ? '1 : '0;
          ifx = $urandom_range(0, 1) ? '1 : '0;
          ify = $urandom_range(0, 1) ? '1 : '0;
          zs = $urandom_range(0, 1) ? '1 : '0;
          lim = $urandom_range(0, 1) ? '1 : dpp_pkg::RAW_W'($urandom_range(1, 4096));
        end
        default: begin
          slope = dpp_pkg::RST_DEPTH_SLOPE;
          offset = dpp_pkg::RST_DEPTH_OFFSET;
          cx = dpp_pkg::RST_CENTER_X;
          cy = dpp_pkg::RST_CENTER_Y;
          ifx = dpp_pkg::RST_INV_FOCAL_X;
          ify = dpp_pkg::RST_INV_FOCAL_Y;
          zs = dpp_pkg::RST_Z_SCALE;
          lim = dpp_pkg::RST_RAW_LIMIT;
        end
      endcase
      program_camera(slope, offset, cx, cy, ifx, ify, zs, lim);
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 115; i++) begin
        if (phase == 4 && i == 57) wait_idle();
        r = $urandom_range(0, 9);
        if (r < 7 && cam_cfg.raw_limit != 0) begin
          raw = dpp_pkg::RAW_W'($urandom_range(0, int'(cam_cfg.raw_limit) - 1));
        end else if (r == 7) begin
          raw = cam_cfg.raw_limit;
        end else begin
          raw = dpp_pkg::RAW_W'($urandom);
        end
        if ($urandom_range(0, 9) != 0) col = dpp_pkg::COL_W'($urandom_range(0, 639));
        else col = dpp_pkg::COL_W'($urandom_range(640, 1023));
        if ($urandom_range(0, 9) != 0) row = dpp_pkg::ROW_W'($urandom_range(1, 480));
        else row = $urandom_range(0, 1) ? 9'd0 : dpp_pkg::ROW_W'($urandom_range(481, 511));
        send_pixel(raw, col, row, pick_gap(burst));
      end
    end
  endtask

  // sample mid-cycle; each result beat is on the ports for one full cycle
  always @(negedge clk) begin
    point_t want;
    if (rst_n && out_valid) begin
      if (expected_points.size() == 0) begin
        $error("result beat with no pending sample");
        mismatches++;
      end else begin
        want = expected_points.pop_front();
        if (out_point_x !== want.x) begin
          $error("point_x expected %0d got %0d", want.x, out_point_x);
          mismatches++;
        end
        if (out_point_y !== want.y) begin
          $error("point_y expected %0d got %0d", want.y, out_point_y);
          mismatches++;
        end
        if (out_point_z !== want.z) begin
          $error("point_z expected %0d got %0d", want.z, out_point_z);
          mismatches++;
        end
        if (out_depth_valid !== want.valid) begin
          $error("depth_valid expected %0d got %0d", want.valid, out_depth_valid);
          mismatches++;
        end
      end
    end
  end

  initial begin
    cam_cfg = '{depth_slope: dpp_pkg::RST_DEPTH_SLOPE, depth_offset: dpp_pkg::RST_DEPTH_OFFSET,
                center_x: dpp_pkg::RST_CENTER_X, center_y: dpp_pkg::RST_CENTER_Y,
                inv_focal_x: dpp_pkg::RST_INV_FOCAL_X, inv_focal_y: dpp_pkg::RST_INV_FOCAL_Y,
                z_scale: dpp_pkg::RST_Z_SCALE, raw_limit: dpp_pkg::RST_RAW_LIMIT};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_default_registers();
    test_register_extremes();
    test_random_traffic();
    wait_idle();
    repeat (dpp_pkg::PIPE_LAT + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("depth_pixel_to_point verification clean");
    end else begin
      $display("depth_pixel_to_point verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("depth_pixel_to_point verification failed");
    $finish;
  end

endmodule
